// ===== rtl/gce_pkg.sv =====
// shared types, constants and control structs of the grid cell enumeration block
package gce_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int CELL_SIZE_W     = 32;
	localparam int MAX_CELLS_DEF   = 64;
	localparam int NUM_AXES        = 3;
	localparam int NUM_BOUNDS      = 2 * NUM_AXES;
	localparam int STATUS_W        = 2;
	localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RESET = 32'd256;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVERTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} box_t;

	typedef struct packed {
		coord_t                cell_x;
		coord_t                cell_y;
		coord_t                cell_z;
		logic                  last;
		logic [STATUS_W-1:0]   status;
	} cell_t;

	// controller to datapath
	typedef struct packed {
		logic                load_box;
		logic                div_start;
		logic                do_check;
		logic                do_mul;
		logic                walk_init;
		logic                emit_cell;
		logic                emit_err;
		logic [STATUS_W-1:0] err_code;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic inverted;
		logic div_done;
		logic div_last;
		logic axis_over;
		logic total_over;
		logic walk_fin;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/gce_divider.sv =====
// shared serial restoring divider, one quotient bit per cycle
module gce_divider #(
	parameter int W = gce_pkg::COORD_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic         rem_nz
);
	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       rem_sh;
	logic [W:0]       rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign ge      = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_nz   = |rem_q;

endmodule

// ===== rtl/gce_datapath.sv =====
// datapath: box and range registers, floor division, count checks, cell walk, output register
module gce_datapath #(
	parameter int MAX_CELLS = gce_pkg::MAX_CELLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gce_pkg::ctrl_cmd_t                   cmd,
	output gce_pkg::dp_status_t                  stat,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gce_pkg::CELL_SIZE_W-1:0]      cfg_data,
	input  gce_pkg::box_t                        in_data,
	output gce_pkg::cell_t                       out_data,
	output logic                                 out_valid,
	input  logic                                 out_ready
);
	import gce_pkg::*;

	localparam int CNT_W = $clog2(MAX_CELLS + 1);
	localparam int IDX_W = $clog2(NUM_BOUNDS);
	localparam int EXT_W = COORD_WIDTH + 2;
	localparam int PXY_W = 2 * CNT_W;
	localparam int TOT_W = 3 * CNT_W;

	logic [CELL_SIZE_W-1:0] cell_size_q;
	logic [CELL_SIZE_W-1:0] divisor;
	box_t                   box_q;
	coord_t                 box_arr [NUM_BOUNDS];
	logic [IDX_W-1:0]       idx_q;
	coord_t                 oper;
	logic [COORD_WIDTH-1:0] mag;
	logic                   neg_q;
	logic                   div_done;
	logic [COORD_WIDTH-1:0] quo;
	logic                   rem_nz;
	logic [COORD_WIDTH:0]   q_ext;
	logic [COORD_WIDTH:0]   fl;
	coord_t                 bnd_q [NUM_BOUNDS];
	logic [CNT_W-1:0]       cnt_q [NUM_AXES];
	logic [NUM_AXES-1:0]    over;
	logic                   axis_over_q;
	logic [PXY_W-1:0]       prod_xy_q;
	logic [TOT_W-1:0]       total;
	coord_t                 walk_x_q, walk_y_q, walk_z_q;
	logic                   walk_fin;
	cell_t                  out_q;
	logic                   out_valid_q;

	// configuration register, zero size behaves as one
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CELL_SIZE_RESET;
		end else if (cfg_valid) begin
			cell_size_q <= cfg_data;
		end
	end
	assign divisor = (cell_size_q == '0) ? CELL_SIZE_W'(1) : cell_size_q;

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			box_q <= in_data;
		end
	end

	assign box_arr[0] = box_q.min_x;
	assign box_arr[1] = box_q.min_y;
	assign box_arr[2] = box_q.min_z;
	assign box_arr[3] = box_q.max_x;
	assign box_arr[4] = box_q.max_y;
	assign box_arr[5] = box_q.max_z;

	// bound select for the shared divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_box) begin
			idx_q <= '0;
		end else if (div_done) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign oper = box_arr[idx_q];
	assign mag  = oper[COORD_WIDTH-1] ? (~oper + COORD_WIDTH'(1)) : oper;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= oper[COORD_WIDTH-1];
		end
	end

	gce_divider #(.W(COORD_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo),
		.rem_nz   (rem_nz)
	);

	// floor correction: negate and round toward minus infinity
	assign q_ext = {1'b0, quo};
	assign fl    = neg_q ? ((COORD_WIDTH + 1)'(0) - q_ext - (COORD_WIDTH + 1)'(rem_nz)) : q_ext;

	always_ff @(posedge clk) begin
		if (div_done) begin
			bnd_q[idx_q] <= fl[COORD_WIDTH-1:0];
		end
	end

	// per-axis cell counts
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		logic [EXT_W-1:0] lo_e, hi_e, cnt_full;
		assign lo_e     = {{2{bnd_q[a][COORD_WIDTH-1]}}, bnd_q[a]};
		assign hi_e     = {{2{bnd_q[a+NUM_AXES][COORD_WIDTH-1]}}, bnd_q[a+NUM_AXES]};
		assign cnt_full = hi_e - lo_e + EXT_W'(1);
		assign over[a]  = cnt_full > EXT_W'(MAX_CELLS);
		always_ff @(posedge clk) begin
			if (cmd.do_check) begin
				cnt_q[a] <= cnt_full[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_check) begin
			axis_over_q <= |over;
		end
		if (cmd.do_mul) begin
			prod_xy_q <= PXY_W'(cnt_q[0]) * PXY_W'(cnt_q[1]);
		end
	end

	assign total = TOT_W'(prod_xy_q) * TOT_W'(cnt_q[2]);

	// cell walk, z fastest
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			walk_x_q <= bnd_q[0];
			walk_y_q <= bnd_q[1];
			walk_z_q <= bnd_q[2];
		end else if (cmd.emit_cell) begin
			if (walk_z_q == bnd_q[5]) begin
				walk_z_q <= bnd_q[2];
				if (walk_y_q == bnd_q[4]) begin
					walk_y_q <= bnd_q[1];
					walk_x_q <= walk_x_q + COORD_WIDTH'(1);
				end else begin
					walk_y_q <= walk_y_q + COORD_WIDTH'(1);
				end
			end else begin
				walk_z_q <= walk_z_q + COORD_WIDTH'(1);
			end
		end
	end

	assign walk_fin = (walk_x_q == bnd_q[3]) && (walk_y_q == bnd_q[4]) && (walk_z_q == bnd_q[5]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cell || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cell) begin
			out_q.cell_x <= walk_x_q;
			out_q.cell_y <= walk_y_q;
			out_q.cell_z <= walk_z_q;
			out_q.last   <= walk_fin;
			out_q.status <= ST_OK;
		end else if (cmd.emit_err) begin
			out_q.cell_x <= '0;
			out_q.cell_y <= '0;
			out_q.cell_z <= '0;
			out_q.last   <= 1'b1;
			out_q.status <= cmd.err_code;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	assign stat.inverted   = (in_data.min_x > in_data.max_x) || (in_data.min_y > in_data.max_y)
	                      || (in_data.min_z > in_data.max_z);
	assign stat.div_done   = div_done;
	assign stat.div_last   = idx_q == IDX_W'(NUM_BOUNDS - 1);
	assign stat.axis_over  = axis_over_q;
	assign stat.total_over = total > TOT_W'(MAX_CELLS);
	assign stat.walk_fin   = walk_fin;
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

// ===== rtl/gce_ctrl.sv =====
// controller: sequences the six divisions, the count checks and the cell walk
module gce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gce_pkg::dp_status_t stat,
	output gce_pkg::ctrl_cmd_t  cmd
);
	import gce_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DSTART = 8'b0000_0010,
		S_DWAIT  = 8'b0000_0100,
		S_CHECK  = 8'b0000_1000,
		S_MUL1   = 8'b0001_0000,
		S_MUL2   = 8'b0010_0000,
		S_WALK   = 8'b0100_0000,
		S_ERR    = 8'b1000_0000
	} state_t;

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		err_d    = err_q;
		cmd      = '0;
		cmd.err_code = err_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_box = 1'b1;
					if (stat.inverted) begin
						err_d   = ST_INVERTED;
						state_d = S_ERR;
					end else begin
						state_d = S_DSTART;
					end
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					state_d = stat.div_last ? S_CHECK : S_DSTART;
				end
			end
			S_CHECK: begin
				cmd.do_check = 1'b1;
				state_d      = S_MUL1;
			end
			S_MUL1: begin
				if (stat.axis_over) begin
					err_d   = ST_OVERFLOW;
					state_d = S_ERR;
				end else begin
					cmd.do_mul = 1'b1;
					state_d    = S_MUL2;
				end
			end
			S_MUL2: begin
				if (stat.total_over) begin
					err_d   = ST_OVERFLOW;
					state_d = S_ERR;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.out_free) begin
					cmd.emit_cell = 1'b1;
					if (stat.walk_fin) begin
						state_d = S_IDLE;
					end
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/grid_cell_enumeration.sv =====
// top level: enumerates the uniform grid cells covered by one axis-aligned box
// sequence: six floor divisions on the one shared serial divider, then check and
//   multiply steps, before the first cell
// throughput: one box at a time; cells then stream one per cycle while out_ready holds
// reset: arst_n low clears control state and sets cell_size to 256
module grid_cell_enumeration #(
	parameter int MAX_CELLS = gce_pkg::MAX_CELLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gce_pkg::CELL_SIZE_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  gce_pkg::box_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output gce_pkg::cell_t                  out_data
);
	import gce_pkg::*;

	// command and status between the controller and the datapath
	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// controller: one box in flight, error and walk sequencing
	gce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: divider, range registers, count checks, walk and output register
	gce_datapath #(.MAX_CELLS(MAX_CELLS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	// a box once accepted keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accepted item");

	// an error item is always the single and final one of its box
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |-> out_data.last)
		else $error("error item without last");

	// error items carry zero cell indexes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_OK) |->
		(out_data.cell_x == '0) && (out_data.cell_y == '0) && (out_data.cell_z == '0))
		else $error("error item with nonzero cell index");

	// a waiting output item holds still until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while waiting");

endmodule
